FILE: src/pngse_pkg.sv
package pngse_pkg;

    localparam int unsigned SIDE        = 128;
    localparam int unsigned MAX_RESULTS = 53;
    localparam int unsigned BLOCK_MAX   = 65535;
    localparam int unsigned ADLER_MOD   = 65521;
    localparam int unsigned SCAN_TOTAL  = SIDE * (1 + 4 * SIDE);
    localparam int unsigned BLOCK_COUNT = (SCAN_TOTAL + BLOCK_MAX - 1) / BLOCK_MAX;
    localparam int unsigned IDAT_LEN    = 2 + 5 * BLOCK_COUNT + SCAN_TOTAL + 4;
    localparam int unsigned HEAD_LAST   = 42;
    localparam int unsigned HEAD_CRC_START = 37;
    localparam int unsigned TAIL_LAST   = 19;
    localparam logic [31:0] CRC_POLY    = 32'hedb88320;
    localparam logic [31:0] ALL_ONES    = 32'hffffffff;
    localparam logic [31:0] IEND_TYPE   = 32'h49454e44;
    localparam logic [31:0] IEND_CRC    = 32'hae426082;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       first;
        logic       col0;
        logic       last;
    } item_t;

    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_HEAD = 5'b00010,
        P_BLK  = 5'b00100,
        P_SCAN = 5'b01000,
        P_TAIL = 5'b10000
    } phase_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hdr_base(input logic [5:0] idx);
        logic [7:0] r;
        if (idx inside {[16:23]}) begin
            r = be_byte(32'(SIDE), idx[1:0]);
        end else if (idx inside {[33:36]}) begin
            r = be_byte(32'(IDAT_LEN), 2'(idx - 6'd33));
        end else begin
            case (idx)
                6'd0: r = 8'd137;
                6'd1: r = 8'd80;
                6'd2: r = 8'd78;
                6'd3: r = 8'd71;
                6'd4: r = 8'd13;
                6'd5: r = 8'd10;
                6'd6: r = 8'd26;
                6'd7: r = 8'd10;
                6'd11: r = 8'd13;
                6'd12: r = 8'h49;
                6'd13: r = 8'h48;
                6'd14: r = 8'h44;
                6'd15: r = 8'h52;
                6'd24: r = 8'd8;
                6'd25: r = 8'd6;
                6'd37: r = 8'h49;
                6'd38: r = 8'h44;
                6'd39: r = 8'h41;
                6'd40: r = 8'h54;
                6'd41: r = 8'h78;
                6'd42: r = 8'h01;
                default: r = 8'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [31:0] ihdr_crc();
        logic [31:0] c;
        c = ALL_ONES;
        for (int i = 12; i <= 28; i++) begin
            c = crc_byte(c, hdr_base(6'(i)));
        end
        return c ^ ALL_ONES;
    endfunction

    localparam logic [31:0] IHDR_CRC = ihdr_crc();

    function automatic logic [7:0] head_byte(input logic [5:0] idx);
        logic [7:0] r;
        if (idx inside {[29:32]}) begin
            r = be_byte(IHDR_CRC, 2'(idx - 6'd29));
        end else begin
            r = hdr_base(idx);
        end
        return r;
    endfunction

endpackage

FILE: src/pngse_front.sv
module pngse_front import pngse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_alpha,
    input  logic        q_full,
    output logic        q_push,
    output item_t       q_item
);

    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [12:0] col_inc, row_inc;
    logic        row_wrap, img_wrap;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        col_inc  = {1'b0, col_reg} + 13'd1;
        row_inc  = {1'b0, row_reg} + 13'd1;
        row_wrap = (col_inc >= 13'(SIDE)) || (col_inc[11:0] == 12'd0);
        img_wrap = row_wrap && ((row_inc >= 13'(SIDE)) || (row_inc[11:0] == 12'd0));
        col_next = col_reg;
        row_next = row_reg;
        if (q_push) begin
            col_next = row_wrap ? 12'd0 : col_inc[11:0];
            if (row_wrap) begin
                row_next = img_wrap ? 12'd0 : row_inc[11:0];
            end
        end
        q_item.red   = s_red;
        q_item.green = s_green;
        q_item.blue  = s_blue;
        q_item.alpha = s_alpha;
        q_item.first = (col_reg == 12'd0) && (row_reg == 12'd0);
        q_item.col0  = (col_reg == 12'd0);
        q_item.last  = img_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 12'd0;
            row_reg <= 12'd0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: src/pngse_queue.sv
module pngse_queue import pngse_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head_item
);

    item_t       slot_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_item  = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: src/pngse_back.sv
module pngse_back import pngse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_file_byte,
    output logic       m_run_last,
    output logic       m_image_done
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  sel_reg, sel_next;
    logic [5:0]  cnt_reg, cnt_next;
    item_t       cur_reg, cur_next;
    logic [15:0] blk_reg, blk_next;
    logic [26:0] scan_reg, scan_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] alow_reg, alow_next, ahigh_reg, ahigh_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next, odone_reg, odone_next;

    logic        adv, emit_ok, item_end, upd_crc, load, bfinal;
    logic [7:0]  byte_c;
    logic [15:0] n_c, nc_c;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_new, hi_new;
    logic        run_last_c;

    assign m_valid      = ovalid_reg;
    assign m_file_byte  = obyte_reg;
    assign m_run_last   = olast_reg;
    assign m_image_done = odone_reg;
    assign q_pop        = load;

    always_comb begin
        emit_ok = (cnt_reg < 6'(MAX_RESULTS));
        adv     = (phase_reg != P_IDLE) && (!emit_ok || !ovalid_reg || m_ready);
        n_c     = (scan_reg < 27'(BLOCK_MAX)) ? scan_reg[15:0] : 16'(BLOCK_MAX);
        nc_c    = ~n_c;
        bfinal  = ({11'd0, n_c} == scan_reg);

        byte_c  = 8'd0;
        upd_crc = 1'b0;
        case (phase_reg)
            P_HEAD: begin
                byte_c  = head_byte(idx_reg);
                upd_crc = (idx_reg >= 6'(HEAD_CRC_START));
            end
            P_BLK: begin
                upd_crc = 1'b1;
                case (idx_reg[2:0])
                    3'd0: byte_c = {7'd0, bfinal};
                    3'd1: byte_c = n_c[7:0];
                    3'd2: byte_c = n_c[15:8];
                    3'd3: byte_c = nc_c[7:0];
                    default: byte_c = nc_c[15:8];
                endcase
            end
            P_SCAN: begin
                upd_crc = 1'b1;
                case (sel_reg)
                    3'd1: byte_c = cur_reg.red;
                    3'd2: byte_c = cur_reg.green;
                    3'd3: byte_c = cur_reg.blue;
                    3'd4: byte_c = cur_reg.alpha;
                    default: byte_c = 8'd0;
                endcase
            end
            P_TAIL: begin
                upd_crc = (idx_reg < 6'd4);
                case (idx_reg[4:2])
                    3'd0: byte_c = be_byte({ahigh_reg, alow_reg}, idx_reg[1:0]);
                    3'd1: byte_c = be_byte(crc_reg ^ ALL_ONES, idx_reg[1:0]);
                    3'd3: byte_c = be_byte(IEND_TYPE, idx_reg[1:0]);
                    3'd4: byte_c = be_byte(IEND_CRC, idx_reg[1:0]);
                    default: byte_c = 8'd0;
                endcase
            end
            default: byte_c = 8'd0;
        endcase

        lo_sum = {1'b0, alow_reg} + {9'd0, byte_c};
        lo_new = (lo_sum >= 17'(ADLER_MOD)) ? 16'(lo_sum - 17'(ADLER_MOD)) : lo_sum[15:0];
        hi_sum = {1'b0, ahigh_reg} + {1'b0, lo_new};
        hi_new = (hi_sum >= 17'(ADLER_MOD)) ? 16'(hi_sum - 17'(ADLER_MOD)) : hi_sum[15:0];

        phase_next = phase_reg;
        idx_next   = idx_reg;
        sel_next   = sel_reg;
        cur_next   = cur_reg;
        blk_next   = blk_reg;
        scan_next  = scan_reg;
        crc_next   = crc_reg;
        alow_next  = alow_reg;
        ahigh_next = ahigh_reg;
        item_end   = 1'b0;

        if (adv) begin
            if (upd_crc) begin
                crc_next = crc_byte(crc_reg, byte_c);
            end
            case (phase_reg)
                P_HEAD: begin
                    if (idx_reg == 6'(HEAD_LAST)) begin
                        idx_next   = 6'd0;
                        phase_next = (blk_reg == 16'd0) ? P_BLK : P_SCAN;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                P_BLK: begin
                    if (idx_reg == 6'd4) begin
                        idx_next   = 6'd0;
                        blk_next   = n_c;
                        phase_next = P_SCAN;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                P_SCAN: begin
                    blk_next   = blk_reg - 16'd1;
                    scan_next  = scan_reg - 27'd1;
                    alow_next  = lo_new;
                    ahigh_next = hi_new;
                    if (sel_reg == 3'd4) begin
                        if (cur_reg.last) begin
                            phase_next = P_TAIL;
                            idx_next   = 6'd0;
                        end else begin
                            item_end = 1'b1;
                        end
                    end else begin
                        sel_next   = sel_reg + 3'd1;
                        phase_next = (blk_next == 16'd0) ? P_BLK : P_SCAN;
                    end
                end
                P_TAIL: begin
                    if (idx_reg == 6'(TAIL_LAST)) begin
                        item_end   = 1'b1;
                        blk_next   = 16'd0;
                        scan_next  = 27'(SCAN_TOTAL);
                        crc_next   = ALL_ONES;
                        alow_next  = 16'd1;
                        ahigh_next = 16'd0;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end

        load = q_valid && ((phase_reg == P_IDLE) || item_end);
        if (item_end && !q_valid) begin
            phase_next = P_IDLE;
        end
        if (load) begin
            cur_next   = q_item;
            idx_next   = 6'd0;
            sel_next   = q_item.col0 ? 3'd0 : 3'd1;
            phase_next = q_item.first ? P_HEAD : ((blk_next == 16'd0) ? P_BLK : P_SCAN);
        end

        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = 6'd0;
        end else if (adv && emit_ok) begin
            cnt_next = cnt_reg + 6'd1;
        end

        run_last_c  = item_end || (cnt_reg == 6'(MAX_RESULTS - 1));
        ovalid_next = ovalid_reg && !m_ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        odone_next  = odone_reg;
        if (adv && emit_ok) begin
            ovalid_next = 1'b1;
            obyte_next  = byte_c;
            olast_next  = run_last_c;
            odone_next  = run_last_c && cur_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
        idx_reg   <= idx_next;
        sel_reg   <= sel_next;
        cnt_reg   <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= P_IDLE;
            ovalid_reg <= 1'b0;
            blk_reg    <= 16'd0;
            scan_reg   <= 27'(SCAN_TOTAL);
            crc_reg    <= ALL_ONES;
            alow_reg   <= 16'd1;
            ahigh_reg  <= 16'd0;
        end else begin
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
            blk_reg    <= blk_next;
            scan_reg   <= scan_next;
            crc_reg    <= crc_next;
            alow_reg   <= alow_next;
            ahigh_reg  <= ahigh_next;
        end
    end

endmodule

FILE: src/png_stored_deflate_encoder.sv
// Channel   Direction  Ports
// pixel     in         s_valid, s_ready, s_red, s_green, s_blue, s_alpha
// file      out        m_valid, m_ready, m_file_byte, m_run_last, m_image_done
//
// One file byte per cycle unless the output stalls or no pixel waits; a steady
// pixel gives 4 bytes, 5 at a scanline start, plus 5 per stored block header,
// 43 for the file head and 20 for the trailer, all from the back end sequencer.
// Reset (aresetn low, synchronous) restarts the image at its first pixel.
// A two-entry queue takes pixels while the output stalls, until it fills.
module png_stored_deflate_encoder import pngse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_alpha,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_file_byte,
    output logic       m_run_last,
    output logic       m_image_done
);

    logic  q_full, q_push, q_pop, q_valid;
    item_t q_in, q_head;

    pngse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_red   (s_red),
        .s_green (s_green),
        .s_blue  (s_blue),
        .s_alpha (s_alpha),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    pngse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_head)
    );

    pngse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_file_byte  (m_file_byte),
        .m_run_last   (m_run_last),
        .m_image_done (m_image_done)
    );

endmodule

FILE: src/pngse_checker.sv
module pngse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_file_byte,
    input logic       m_run_last,
    input logic       m_image_done
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_file_byte))
        else $error("stalled file byte changed");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_run_last)
        else $error("image end without transaction end");

    a_done_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_file_byte == 8'h82)
        else $error("image end not on trailer checksum");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind png_stored_deflate_encoder pngse_checker u_pngse_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_file_byte  (m_file_byte),
    .m_run_last   (m_run_last),
    .m_image_done (m_image_done)
);

FILE: test/png_stored_deflate_encoder_tb.sv
`timescale 1ns / 1ps

module png_stored_deflate_encoder_tb;
    import pngse_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_PIXELS = 110;
    localparam int unsigned TAIL_PIXELS = 30;

    typedef struct {
        logic [7:0] file_byte;
        logic       run_last;
        logic       image_done;
    } file_byte_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       chk_byte;
        logic [7:0] first_byte;
    } pixel_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_red = '0;
    logic [7:0] s_green = '0;
    logic [7:0] s_blue = '0;
    logic [7:0] s_alpha = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_file_byte;
    logic       m_run_last;
    logic       m_image_done;

    png_stored_deflate_encoder dut (.*);

    always #6 aclk = ~aclk;

    // encoder state mirror
    logic [11:0] col_cnt;
    logic [11:0] row_cnt;
    logic [15:0] blk_left;
    logic [26:0] scan_left;
    logic [31:0] idat_crc;
    logic [15:0] adl_lo;
    logic [15:0] adl_hi;

    file_byte_t  png_bytes[$];
    file_byte_t  run_bytes[$];
    pixel_row_t  typed_first[$];
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    logic        quiet_tail = 1'b0;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = (r >> 1) ^ (32'hedb88320 & {32{r[0]}});
        return r;
    endfunction

    task automatic emit(input logic [7:0] b);
        file_byte_t e;
        e.file_byte = b;
        e.run_last = 1'b0;
        e.image_done = 1'b0;
        if (run_bytes.size() < MAX_RESULTS)
            run_bytes.insert(run_bytes.size(), e);
    endtask

    task automatic emit_be32(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            emit(w[8*i +: 8]);
    endtask

    task automatic emit_idat(input logic [7:0] b);
        idat_crc = crc_step(idat_crc, b);
        emit(b);
    endtask

    task automatic emit_scan(input logic [7:0] b);
        logic [26:0] n;
        logic [15:0] nc;
        if (blk_left == 16'd0) begin
            n = (scan_left < 27'(BLOCK_MAX)) ? scan_left : 27'(BLOCK_MAX);
            nc = ~n[15:0];
            emit_idat((n == scan_left) ? 8'd1 : 8'd0);
            emit_idat(n[7:0]);
            emit_idat(n[15:8]);
            emit_idat(nc[7:0]);
            emit_idat(nc[15:8]);
            blk_left = n[15:0];
        end
        emit_idat(b);
        blk_left = blk_left - 16'd1;
        scan_left = scan_left - 27'd1;
        adl_lo = 16'((32'(adl_lo) + 32'(b)) % ADLER_MOD);
        adl_hi = 16'((32'(adl_hi) + 32'(adl_lo)) % ADLER_MOD);
    endtask

    task automatic emit_chunk(input logic [31:0] ctype, input logic [7:0] data[], input int len);
        logic [31:0] c;
        c = 32'hffffffff;
        emit_be32(32'(len));
        for (int i = 3; i >= 0; i--) begin
            c = crc_step(c, ctype[8*i +: 8]);
            emit(ctype[8*i +: 8]);
        end
        for (int i = 0; i < len; i++) begin
            c = crc_step(c, data[i]);
            emit(data[i]);
        end
        emit_be32(c ^ 32'hffffffff);
    endtask

    task automatic restart_image();
        col_cnt = '0;
        row_cnt = '0;
        blk_left = '0;
        scan_left = 27'(SCAN_TOTAL);
        idat_crc = 32'hffffffff;
        adl_lo = 16'd1;
        adl_hi = 16'd0;
    endtask

    task automatic encode_pixel(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] a);
        logic [7:0]  sig[];
        logic [7:0]  hdr[];
        logic [31:0] side_w;
        logic [31:0] adler;
        logic        done;
        done = 1'b0;
        run_bytes.delete();
        if (col_cnt == 0 && row_cnt == 0) begin
            sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
            foreach (sig[i]) emit(sig[i]);
            side_w = 32'(SIDE);
            hdr = '{side_w[31:24], side_w[23:16], side_w[15:8], side_w[7:0],
                    side_w[31:24], side_w[23:16], side_w[15:8], side_w[7:0],
                    8'd8, 8'd6, 8'd0, 8'd0, 8'd0};
            emit_chunk(32'h49484452, hdr, 13);
            emit_be32(32'(IDAT_LEN));
            emit_idat(8'h49);
            emit_idat(8'h44);
            emit_idat(8'h41);
            emit_idat(8'h54);
            emit_idat(8'h78);
            emit_idat(8'h01);
        end
        if (col_cnt == 0)
            emit_scan(8'd0);
        emit_scan(r);
        emit_scan(g);
        emit_scan(b);
        emit_scan(a);
        col_cnt = col_cnt + 12'd1;
        if ({1'b0, col_cnt} >= 13'(SIDE) || col_cnt == 0) begin
            col_cnt = '0;
            row_cnt = row_cnt + 12'd1;
            if ({1'b0, row_cnt} >= 13'(SIDE) || row_cnt == 0) begin
                adler = {adl_hi, adl_lo};
                emit_idat(adler[31:24]);
                emit_idat(adler[23:16]);
                emit_idat(adler[15:8]);
                emit_idat(adler[7:0]);
                emit_be32(idat_crc ^ 32'hffffffff);
                hdr = new[0];
                emit_chunk(32'h49454e44, hdr, 0);
                done = 1'b1;
                restart_image();
            end
        end
        if (run_bytes.size() > 0) begin
            run_bytes[run_bytes.size() - 1].run_last = 1'b1;
            run_bytes[run_bytes.size() - 1].image_done = done;
        end
        foreach (run_bytes[i]) png_bytes.insert(png_bytes.size(), run_bytes[i]);
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        err_count++;
        if (err_count <= 40)
            $display("mismatch %s: got %0h expected %0h at cycle %0d",
                     what, got, want, cycle_count);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        s_alpha <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        encode_pixel(r, g, b, a);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("png_stored_deflate_encoder regression: fail");
            $finish;
        end
    end

    // hold off the file channel in bursts
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        file_byte_t e;
        pixel_row_t t;
        if (aresetn && m_valid && m_ready) begin
            if (png_bytes.size() == 0) begin
                report("unexpected transaction", m_file_byte, 8'h00);
            end else begin
                e = png_bytes.pop_front();
                if (typed_first.size() > 0) begin
                    t = typed_first.pop_front();
                    if (t.chk_byte && m_file_byte !== t.first_byte)
                        report("signature", m_file_byte, t.first_byte);
                end
                if (m_file_byte !== e.file_byte)
                    report("file_byte", m_file_byte, e.file_byte);
                if (m_run_last !== e.run_last)
                    report("run_last", 8'(m_run_last), 8'(e.run_last));
                if (m_image_done !== e.image_done)
                    report("image_done", 8'(m_image_done), 8'(e.image_done));
            end
        end
    end

    pixel_row_t directed[] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd137},
        '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{8'h00, 8'hff, 8'h00, 8'hff, 1'b0, 8'h00},
        '{8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 8'h00},
        '{8'h55, 8'haa, 8'h55, 8'haa, 1'b0, 8'h00},
        '{8'haa, 8'h55, 8'haa, 8'h55, 1'b0, 8'h00},
        '{8'h01, 8'h80, 8'h7f, 8'hfe, 1'b0, 8'h00},
        '{8'h80, 8'h01, 8'hfe, 8'h7f, 1'b0, 8'h00},
        '{8'h0f, 8'hf0, 8'h3c, 8'hc3, 1'b0, 8'h00},
        '{8'hff, 8'h00, 8'h00, 8'hff, 1'b0, 8'h00}
    };

    initial begin
        int unsigned sent;
        int unsigned drain;
        restart_image();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        typed_first.insert(typed_first.size(), directed[0]);
        foreach (directed[i])
            send_pixel(directed[i].red, directed[i].green, directed[i].blue, directed[i].alpha);
        sent = directed.size();
        repeat (RANDOM_PIXELS) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
        end
        // send the last pixels at full rate
        quiet_tail = 1'b1;
        repeat (TAIL_PIXELS) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
        end
        s_valid <= 1'b0;
        drain = 0;
        while (png_bytes.size() > 0 && drain < 10000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (60) @(posedge aclk);
        if (err_count == 0 && png_bytes.size() == 0) begin
            $display("png_stored_deflate_encoder regression: pass");
        end else begin
            $display("png_stored_deflate_encoder regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
src/pngse_pkg.sv
src/pngse_front.sv
src/pngse_queue.sv
src/pngse_back.sv
src/png_stored_deflate_encoder.sv
src/pngse_checker.sv
test/png_stored_deflate_encoder_tb.sv
